// ===== rtl/rdc_pkg.sv =====
// Types, mode codes, drive patterns and register indexes for the
// refrigeration defrost controller. Depends on nothing.
`default_nettype none

package rdc_pkg;

	localparam int ADC_W = 10;
	localparam int CFG_IDX_W = 3;
	localparam int PAT_W = 7;

	typedef enum logic [2:0] {
		MODE_WAIT    = 3'd0,
		MODE_COMP    = 3'd1,
		MODE_DEFROST = 3'd2,
		MODE_FANS    = 3'd3,
		MODE_ERR1    = 3'd4,
		MODE_ERR2    = 3'd5
	} mode_t;

	// pattern: bit0 compressor, bit1 outer fan, bit2 inner fan, bits 6:3 LEDs D..A
	localparam logic [PAT_W-1:0] PAT_OFF     = 7'b0000_000;
	localparam logic [PAT_W-1:0] PAT_IDLE    = 7'b1111_100;
	localparam logic [PAT_W-1:0] PAT_COMP    = 7'b0101_111;
	localparam logic [PAT_W-1:0] PAT_DEFROST = 7'b1100_100;
	localparam logic [PAT_W-1:0] PAT_FANS    = 7'b0010_110;
	localparam logic [PAT_W-1:0] PAT_ERR1    = 7'b1000_000;
	localparam logic [PAT_W-1:0] PAT_ERR2    = 7'b0100_000;

	localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND           = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FREEZE_LEVEL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_THAWED_LEVEL   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_ALARM = 3'd4;

	localparam logic [ADC_W-1:0] RST_SETPOINT       = 10'd512;
	localparam logic [ADC_W-1:0] RST_BAND           = 10'd16;
	localparam logic [ADC_W-1:0] RST_FREEZE_LEVEL   = 10'd50;
	localparam logic [ADC_W-1:0] RST_THAWED_LEVEL   = 10'd100;
	localparam logic [ADC_W-1:0] RST_PRESSURE_ALARM = 10'd100;

	typedef struct packed {
		logic [ADC_W-1:0] ambient_temp;
		logic [ADC_W-1:0] evaporator_temp;
		logic [ADC_W-1:0] low_pressure;
		logic             reset_button;
	} sample_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       compressor_on;
		logic       outer_fan_on;
		logic       inner_fan_on;
		logic [3:0] leds;
	} result_t;

	typedef struct packed {
		logic [ADC_W-1:0] setpoint;
		logic [ADC_W-1:0] band;
		logic [ADC_W-1:0] freeze_level;
		logic [ADC_W-1:0] thawed_level;
		logic [ADC_W-1:0] pressure_alarm;
	} cfg_regs_t;

	typedef struct packed {
		mode_t            mode;
		logic [PAT_W-1:0] pattern;
	} ctrl_state_t;

endpackage

`default_nettype wire

// ===== rtl/rdc_cfg_regs.sv =====
// Threshold register file of the defrost controller.
// Depends on rdc_pkg.
`default_nettype none

module rdc_cfg_regs
	import rdc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ADC_W-1:0]     cfg_data,
	output cfg_regs_t                 regs
);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.setpoint       <= RST_SETPOINT;
			regs_q.band           <= RST_BAND;
			regs_q.freeze_level   <= RST_FREEZE_LEVEL;
			regs_q.thawed_level   <= RST_THAWED_LEVEL;
			regs_q.pressure_alarm <= RST_PRESSURE_ALARM;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SETPOINT:       regs_q.setpoint       <= cfg_data;
				CFG_BAND:           regs_q.band           <= cfg_data;
				CFG_FREEZE_LEVEL:   regs_q.freeze_level   <= cfg_data;
				CFG_THAWED_LEVEL:   regs_q.thawed_level   <= cfg_data;
				CFG_PRESSURE_ALARM: regs_q.pressure_alarm <= cfg_data;
				default: ; // drop writes beyond the list
			endcase
		end
	end

	assign regs = regs_q;

endmodule

`default_nettype wire

// ===== rtl/rdc_next_state.sv =====
// Next mode and drive pattern of the defrost controller for one item.
// Depends on rdc_pkg.
`default_nettype none

module rdc_next_state
	import rdc_pkg::*;
(
	input  wire sample_t     sample,
	input  wire cfg_regs_t   regs,
	input  wire ctrl_state_t cur,
	output ctrl_state_t      nxt
);

	logic [ADC_W:0] hi_sum;
	logic [ADC_W:0] amb_plus_band;
	logic           amb_above_hi;
	logic           amb_below_lo;
	logic           evap_frozen;
	logic           evap_thawed;
	logic           pres_low;

	// amb < setpoint - band is amb + band < setpoint, kept unsigned and one bit wider
	assign hi_sum        = {1'b0, regs.setpoint} + {1'b0, regs.band};
	assign amb_plus_band = {1'b0, sample.ambient_temp} + {1'b0, regs.band};
	assign amb_above_hi  = {1'b0, sample.ambient_temp} > hi_sum;
	assign amb_below_lo  = amb_plus_band < {1'b0, regs.setpoint};
	assign evap_frozen   = sample.evaporator_temp < regs.freeze_level;
	assign evap_thawed   = sample.evaporator_temp > regs.thawed_level;
	assign pres_low      = sample.low_pressure < regs.pressure_alarm;

	always_comb begin
		nxt = cur;
		unique case (cur.mode)
			MODE_COMP: begin
				if (evap_frozen) begin
					nxt = '{mode: MODE_DEFROST, pattern: PAT_DEFROST};
				end else if (amb_below_lo) begin
					nxt = '{mode: MODE_FANS, pattern: PAT_FANS};
				end else begin
					nxt = '{mode: MODE_COMP, pattern: PAT_COMP};
				end
			end
			MODE_DEFROST: begin
				if (evap_thawed) begin
					nxt.mode = MODE_ERR1; // hold pattern
				end else begin
					nxt = '{mode: MODE_DEFROST, pattern: PAT_DEFROST};
				end
			end
			MODE_FANS: begin
				if (pres_low) begin
					nxt.mode = MODE_ERR2; // hold pattern
				end else if (!evap_thawed) begin
					nxt = '{mode: MODE_FANS, pattern: PAT_FANS};
				end else begin
					nxt = '{mode: MODE_WAIT, pattern: PAT_IDLE};
				end
			end
			MODE_ERR1: begin
				if (sample.reset_button) begin
					nxt = '{mode: MODE_WAIT, pattern: PAT_IDLE};
				end else begin
					nxt = '{mode: MODE_ERR1, pattern: PAT_ERR1};
				end
			end
			MODE_ERR2: begin
				if (sample.reset_button) begin
					nxt = '{mode: MODE_WAIT, pattern: PAT_IDLE};
				end else begin
					nxt = '{mode: MODE_ERR2, pattern: PAT_ERR2};
				end
			end
			default: begin
				if (amb_above_hi) begin
					nxt.mode = MODE_COMP; // hold pattern
				end else begin
					nxt = '{mode: MODE_WAIT, pattern: PAT_IDLE};
				end
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/refrigeration_defrost_controller.sv =====
// Top level of the refrigeration defrost controller: input register, state and
// result register, threshold registers. Depends on rdc_pkg, rdc_cfg_regs, rdc_next_state.
//
//   channel   direction  handshake                    payload
//   sample    in         sample_valid/sample_ready    sample_t
//   result    out        result_valid/result_ready    result_t
//   cfg       in         cfg_we (no wait)             cfg_index, cfg_data
//
// One item per clock while result_ready holds; an item lands in the input register at
// the edge that accepts it, then reaches the result port via the state/result register.
// The combinational mode update closes the loop through the state register.
// Reset restores the threshold defaults, wait mode and all drives off.
// A stalled result holds the state; the input register still takes one item.
`default_nettype none

module refrigeration_defrost_controller
	import rdc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 sample_valid,
	output logic                      sample_ready,
	input  wire sample_t              sample,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output result_t                   result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ADC_W-1:0]     cfg_data
);

	cfg_regs_t   regs;
	sample_t     sample_s1;
	logic        valid_s1;
	ctrl_state_t state_q;
	ctrl_state_t nxt;
	logic        result_valid_q;
	logic        advance;
	logic        step_fire;

	rdc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	rdc_next_state u_next_state (
		.sample (sample_s1),
		.regs   (regs),
		.cur    (state_q),
		.nxt    (nxt)
	);

	assign advance      = !result_valid_q || result_ready;
	assign step_fire    = valid_s1 && advance;
	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			sample_s1 <= sample;
		end
	end

	// the result register is the controller state itself
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= '{mode: MODE_WAIT, pattern: PAT_OFF};
			result_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				result_valid_q <= valid_s1;
			end
			if (step_fire) begin
				state_q <= nxt;
			end
		end
	end

	assign result_valid         = result_valid_q;
	assign result.mode          = state_q.mode;
	assign result.compressor_on = state_q.pattern[0];
	assign result.outer_fan_on  = state_q.pattern[1];
	assign result.inner_fan_on  = state_q.pattern[2];
	assign result.leds          = state_q.pattern[6:3];

	a_state_holds_without_step: assert property (@(posedge clk) disable iff (!arst_n)
		!step_fire |=> state_q == $past(state_q))
		else $error("state changed without a step");

	a_err1_keeps_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		(step_fire && state_q.mode == MODE_DEFROST && nxt.mode == MODE_ERR1)
		|=> state_q.pattern == $past(state_q.pattern))
		else $error("entering error one changed the drive pattern");

	a_error_compressor_off: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.mode == MODE_ERR1 || state_q.mode == MODE_ERR2) |-> !state_q.pattern[0])
		else $error("compressor driven in an error state");

	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> (valid_s1 && result_valid_q && !result_ready))
		else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking bench for the refrigeration defrost controller: a directed
// table of ticks, then random ticks under several threshold settings.
// Depends on rdc_pkg and refrigeration_defrost_controller.
`timescale 1ns / 100ps

module tb_top;
	import rdc_pkg::*;

	localparam int ADC_MAX = (1 << ADC_W) - 1;
	localparam int CYCLE_LIMIT = 250000;
	localparam int ITEMS_PER_PHASE = 203;
	localparam int PHASE_COUNT = 9;
	localparam int HOLD_OFF_CYCLES = 400;

	typedef struct packed {
		logic [ADC_W-1:0] amb;
		logic [ADC_W-1:0] evap;
		logic [ADC_W-1:0] pres;
		logic             btn;
		logic             typed;
		result_t          want;
	} tick_row_t;

	// Walk every transition; typed rows carry the expectation read straight off the spec.
	localparam int ROW_COUNT = 24;
	localparam tick_row_t tick_rows[ROW_COUNT] = '{
		'{10'd528,  10'd500,  10'd500,  1'b0, 1'b1, '{MODE_WAIT, 1'b0, 1'b0, 1'b1, 4'b1111}},
		'{10'd529,  10'd500,  10'd500,  1'b0, 1'b1, '{MODE_COMP, 1'b0, 1'b0, 1'b1, 4'b1111}},
		'{10'd1023, 10'd1023, 10'd1023, 1'b1, 1'b1, '{MODE_COMP, 1'b1, 1'b1, 1'b1, 4'b0101}},
		'{10'd496,  10'd50,   10'd500,  1'b0, 1'b0, '0},
		'{10'd0,    10'd49,   10'd500,  1'b0, 1'b0, '0},
		'{10'd500,  10'd100,  10'd500,  1'b0, 1'b0, '0},
		'{10'd500,  10'd101,  10'd500,  1'b0, 1'b1, '{MODE_ERR1, 1'b0, 1'b0, 1'b1, 4'b1100}},
		'{10'd500,  10'd500,  10'd500,  1'b0, 1'b1, '{MODE_ERR1, 1'b0, 1'b0, 1'b0, 4'b1000}},
		'{10'd500,  10'd500,  10'd500,  1'b1, 1'b1, '{MODE_WAIT, 1'b0, 1'b0, 1'b1, 4'b1111}},
		'{10'd1023, 10'd500,  10'd500,  1'b0, 1'b0, '0},
		'{10'd495,  10'd50,   10'd500,  1'b0, 1'b0, '0},
		'{10'd500,  10'd100,  10'd100,  1'b0, 1'b0, '0},
		'{10'd500,  10'd100,  10'd99,   1'b0, 1'b1, '{MODE_ERR2, 1'b0, 1'b1, 1'b1, 4'b0010}},
		'{10'd500,  10'd500,  10'd500,  1'b0, 1'b1, '{MODE_ERR2, 1'b0, 1'b0, 1'b0, 4'b0100}},
		'{10'd500,  10'd500,  10'd500,  1'b1, 1'b0, '0},
		'{10'd1023, 10'd500,  10'd500,  1'b0, 1'b0, '0},
		'{10'd0,    10'd1023, 10'd0,    1'b0, 1'b0, '0},
		'{10'd500,  10'd101,  10'd1023, 1'b0, 1'b0, '0},
		'{10'd0,    10'd0,    10'd0,    1'b0, 1'b1, '{MODE_WAIT, 1'b0, 1'b0, 1'b1, 4'b1111}},
		'{10'd1023, 10'd0,    10'd0,    1'b1, 1'b0, '0},
		'{10'd0,    10'd0,    10'd0,    1'b1, 1'b0, '0},
		'{10'd1023, 10'd0,    10'd0,    1'b1, 1'b0, '0},
		'{10'd1023, 10'd1023, 10'd1023, 1'b0, 1'b0, '0},
		'{10'd0,    10'd1023, 10'd1023, 1'b1, 1'b0, '0}
	};

	// Fixed threshold settings: defaults, all low, all high, band wider than setpoint, mid.
	localparam int FIXED_SETTINGS = 5;
	localparam cfg_regs_t fixed_settings[FIXED_SETTINGS] = '{
		'{RST_SETPOINT, RST_BAND, RST_FREEZE_LEVEL, RST_THAWED_LEVEL, RST_PRESSURE_ALARM},
		'{10'd0, 10'd0, 10'd0, 10'd0, 10'd0},
		'{10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023},
		'{10'd20, 10'd600, 10'd300, 10'd700, 10'd200},
		'{10'd300, 10'd40, 10'd200, 10'd500, 10'd300}
	};

	logic    clk = 1'b0;
	logic    arst_n;
	logic    sample_valid;
	logic    sample_ready;
	sample_t sample;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;
	logic    cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADC_W-1:0]     cfg_data;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	int cycle_count = 0;
	int mismatch_count = 0;

	// predicted controller state and thresholds
	cfg_regs_t        thresholds;
	mode_t            tracked_mode;
	logic [PAT_W-1:0] tracked_pattern;
	result_t          expected_outputs[$];

	refrigeration_defrost_controller i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic result_t advance_controller(sample_t s);
		int hi;
		int lo;
		hi = int'(thresholds.setpoint) + int'(thresholds.band);
		lo = int'(thresholds.setpoint) - int'(thresholds.band);
		case (tracked_mode)
			MODE_COMP: begin
				if (s.evaporator_temp < thresholds.freeze_level) begin
					tracked_pattern = PAT_DEFROST;
					tracked_mode = MODE_DEFROST;
				end else if (int'(s.ambient_temp) < lo) begin
					tracked_pattern = PAT_FANS;
					tracked_mode = MODE_FANS;
				end else begin
					tracked_pattern = PAT_COMP;
				end
			end
			MODE_DEFROST: begin
				if (s.evaporator_temp > thresholds.thawed_level)
					tracked_mode = MODE_ERR1;
				else
					tracked_pattern = PAT_DEFROST;
			end
			MODE_FANS: begin
				if (s.low_pressure < thresholds.pressure_alarm) begin
					tracked_mode = MODE_ERR2;
				end else if (s.evaporator_temp <= thresholds.thawed_level) begin
					tracked_pattern = PAT_FANS;
				end else begin
					tracked_pattern = PAT_IDLE;
					tracked_mode = MODE_WAIT;
				end
			end
			MODE_ERR1, MODE_ERR2: begin
				if (s.reset_button) begin
					tracked_pattern = PAT_IDLE;
					tracked_mode = MODE_WAIT;
				end else begin
					tracked_pattern = (tracked_mode == MODE_ERR1) ? PAT_ERR1 : PAT_ERR2;
				end
			end
			default: begin
				if (int'(s.ambient_temp) > hi) begin
					tracked_mode = MODE_COMP;
				end else begin
					tracked_pattern = PAT_IDLE;
					tracked_mode = MODE_WAIT;
				end
			end
		endcase
		return '{mode: tracked_mode, compressor_on: tracked_pattern[0],
			outer_fan_on: tracked_pattern[1], inner_fan_on: tracked_pattern[2],
			leds: tracked_pattern[6:3]};
	endfunction

	// Readings uniform most often, else close to a threshold or at the rails.
	function automatic logic [ADC_W-1:0] reading_near(int level);
		int pick;
		int v;
		pick = $urandom_range(99);
		if (pick < 45)
			v = $urandom_range(ADC_MAX);
		else if (pick < 77)
			v = level + int'($urandom_range(6)) - 3;
		else if (pick < 89)
			v = 0;
		else
			v = ADC_MAX;
		if (v < 0)
			v = 0;
		if (v > ADC_MAX)
			v = ADC_MAX;
		return v[ADC_W-1:0];
	endfunction

	function automatic sample_t random_tick();
		sample_t s;
		int amb_level;
		int evap_level;
		amb_level = $urandom_range(1) ? int'(thresholds.setpoint) + int'(thresholds.band)
			: int'(thresholds.setpoint) - int'(thresholds.band);
		evap_level = $urandom_range(1) ? int'(thresholds.freeze_level)
			: int'(thresholds.thawed_level);
		s.ambient_temp = reading_near(amb_level);
		s.evaporator_temp = reading_near(evap_level);
		s.low_pressure = reading_near(int'(thresholds.pressure_alarm));
		s.reset_button = ($urandom_range(99) < 35);
		return s;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatch_count++;
		$display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// Offer one item, hold it until accepted, then queue what it should produce.
	task automatic offer_tick(sample_t s, logic use_typed, result_t typed_want);
		result_t predicted;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid = 1'b0;
			@(negedge clk);
		end
		sample_valid = 1'b1;
		sample = s;
		do
			@(posedge clk);
		while (!sample_ready);
		predicted = advance_controller(s);
		expected_outputs.push_back(use_typed ? typed_want : predicted);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADC_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			CFG_SETPOINT:       thresholds.setpoint = val;
			CFG_BAND:           thresholds.band = val;
			CFG_FREEZE_LEVEL:   thresholds.freeze_level = val;
			CFG_THAWED_LEVEL:   thresholds.thawed_level = val;
			CFG_PRESSURE_ALARM: thresholds.pressure_alarm = val;
			default: ;
		endcase
	endtask

	// Drop valid and wait until every queued result has come out.
	task automatic drain();
		@(negedge clk);
		sample_valid = 1'b0;
		while (expected_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_ready = 1'b0;
			hold_left--;
		end else begin
			result_ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_outputs.size() == 0) begin
				report_mismatch("unexpected result", int'(result), 0);
			end else begin
				want = expected_outputs.pop_front();
				if (result.mode !== want.mode)
					report_mismatch("mode", int'(result.mode), int'(want.mode));
				if (result.compressor_on !== want.compressor_on)
					report_mismatch("compressor_on", int'(result.compressor_on),
						int'(want.compressor_on));
				if (result.outer_fan_on !== want.outer_fan_on)
					report_mismatch("outer_fan_on", int'(result.outer_fan_on),
						int'(want.outer_fan_on));
				if (result.inner_fan_on !== want.inner_fan_on)
					report_mismatch("inner_fan_on", int'(result.inner_fan_on),
						int'(want.inner_fan_on));
				if (result.leds !== want.leds)
					report_mismatch("leds", int'(result.leds), int'(want.leds));
			end
		end
	end

	initial begin
		cfg_regs_t next_cfg;
		sample_t s;
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		thresholds = '{RST_SETPOINT, RST_BAND, RST_FREEZE_LEVEL, RST_THAWED_LEVEL,
			RST_PRESSURE_ALARM};
		tracked_mode = MODE_WAIT;
		tracked_pattern = PAT_OFF;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int r = 0; r < ROW_COUNT; r++) begin
			s = '{tick_rows[r].amb, tick_rows[r].evap, tick_rows[r].pres, tick_rows[r].btn};
			offer_tick(s, tick_rows[r].typed, tick_rows[r].want);
		end

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			drain();
			if (phase < FIXED_SETTINGS) begin
				next_cfg = fixed_settings[phase];
			end else begin
				next_cfg.setpoint = ADC_W'($urandom_range(900, 100));
				next_cfg.band = ADC_W'($urandom_range(120));
				next_cfg.freeze_level = ADC_W'($urandom_range(400));
				next_cfg.thawed_level = ADC_W'($urandom_range(ADC_MAX, next_cfg.freeze_level));
				next_cfg.pressure_alarm = ADC_W'($urandom_range(300));
			end
			write_reg(CFG_SETPOINT, next_cfg.setpoint);
			write_reg(CFG_BAND, next_cfg.band);
			write_reg(CFG_FREEZE_LEVEL, next_cfg.freeze_level);
			write_reg(CFG_THAWED_LEVEL, next_cfg.thawed_level);
			write_reg(CFG_PRESSURE_ALARM, next_cfg.pressure_alarm);
			// indexes past the register list must be ignored
			write_reg(CFG_PRESSURE_ALARM + CFG_IDX_W'($urandom_range(3, 1)),
				ADC_W'($urandom_range(ADC_MAX)));
			@(negedge clk);
			cfg_we = 1'b0;

			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			// last phase: block the output long enough to back up the input
			if (phase == PHASE_COUNT - 1)
				hold_left = HOLD_OFF_CYCLES;

			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				offer_tick(random_tick(), 1'b0, '0);
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
